/* sv/octahedral_normal_encoder_assert.svh */
// Assertion macros for the octahedral normal encoder.
// Included by the top level; no other dependencies.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define OCT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("oct: assertion failed");
`define OCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("oct: assertion failed");
`else
`define OCT_ASSERT(lbl, clk, rst_n, prop)
`define OCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/oct_pkg.sv */
// Package for the octahedral normal encoder: widths and divider word types.
// No dependencies.
`default_nettype none
package oct_pkg;
	localparam int COMPONENT_BITS = 16;
	localparam int CODE_BITS      = 10;
	localparam int SUM_W          = COMPONENT_BITS + 1;
	localparam int DEN_W          = COMPONENT_BITS + 2;
	localparam int NUM_W          = DEN_W + CODE_BITS;

	typedef struct packed {
		logic [DEN_W-1:0]     rem;
		logic [CODE_BITS-1:0] low;
		logic [CODE_BITS-1:0] quo;
	} oct_lane_t;

	typedef struct packed {
		logic             zero;
		logic [DEN_W-1:0] den;
		oct_lane_t        u;
		oct_lane_t        v;
	} oct_word_t;
endpackage
`default_nettype wire

/* sv/oct_in_if.sv */
// Input channel of the octahedral normal encoder: one normal vector per word.
// Depends on oct_pkg.
`default_nettype none
interface oct_in_if
	import oct_pkg::*;
;
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] normal_x;
	logic signed [COMPONENT_BITS-1:0] normal_y;
	logic signed [COMPONENT_BITS-1:0] normal_z;

	modport source (output valid, normal_x, normal_y, normal_z, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

/* sv/oct_out_if.sv */
// Output channel of the octahedral normal encoder: two codes and a zero flag per word.
// Depends on oct_pkg.
`default_nettype none
interface oct_out_if
	import oct_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] coord_u;
	logic [CODE_BITS-1:0] coord_v;
	logic                 zero_vector;

	modport source (output valid, coord_u, coord_v, zero_vector, input ready);
	modport sink (input valid, coord_u, coord_v, zero_vector, output ready);
endinterface
`default_nettype wire

/* sv/octahedral_normal_encoder.sv */
// An accepted vector passes the input register, w[0] and the CODE_BITS divider cells to the result word.
// Throughput: one word per cycle while results are accepted; the chain of CODE_BITS divider cells sets the depth.
// The whole pipeline holds while a result waits unaccepted.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
`default_nettype none
`include "octahedral_normal_encoder_assert.svh"
module octahedral_normal_encoder
	import oct_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	oct_in_if.sink   normal,
	oct_out_if.source coord
);
	logic                             en;
	logic                             vld_s1;
	logic signed [COMPONENT_BITS-1:0] x_s1;
	logic signed [COMPONENT_BITS-1:0] y_s1;
	logic [COMPONENT_BITS-1:0]        mx_s1;
	logic [COMPONENT_BITS-1:0]        my_s1;
	logic [SUM_W-1:0]                 s_s1;
	logic                             zneg_s1;
	logic [COMPONENT_BITS-1:0]        mx;
	logic [COMPONENT_BITS-1:0]        my;
	logic [COMPONENT_BITS-1:0]        mz;
	logic [DEN_W-1:0]                 pu;
	logic [DEN_W-1:0]                 pv;
	logic signed [DEN_W:0]            xs;
	logic signed [DEN_W:0]            ys;
	logic [NUM_W-1:0]                 nu;
	logic [NUM_W-1:0]                 nv;
	logic [DEN_W-1:0]                 twice_s;
	oct_word_t                        word_d;
	logic                             vld [CODE_BITS+1];
	oct_word_t                        w   [CODE_BITS+1];

	assign en           = !vld[CODE_BITS] || coord.ready;
	assign normal.ready = en;

	always_comb begin
		mx = normal.normal_x[COMPONENT_BITS-1] ? (~normal.normal_x + 1'b1) : normal.normal_x;
		my = normal.normal_y[COMPONENT_BITS-1] ? (~normal.normal_y + 1'b1) : normal.normal_y;
		mz = normal.normal_z[COMPONENT_BITS-1] ? (~normal.normal_z + 1'b1) : normal.normal_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= normal.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= normal.normal_x;
			y_s1    <= normal.normal_y;
			mx_s1   <= mx;
			my_s1   <= my;
			s_s1    <= SUM_W'(mx) + SUM_W'(my) + SUM_W'(mz);
			zneg_s1 <= normal.normal_z[COMPONENT_BITS-1];
		end
	end

	// a + s when z >= 0, else the folded (s - |b|)*sign(a) + s; always in [0, 2s]
	always_comb begin
		twice_s = {s_s1, 1'b0};
		xs      = (DEN_W+1)'(x_s1) + $signed({2'b00, s_s1});
		ys      = (DEN_W+1)'(y_s1) + $signed({2'b00, s_s1});
		if (zneg_s1) begin
			pu = x_s1[COMPONENT_BITS-1] ? DEN_W'(my_s1) : twice_s - DEN_W'(my_s1);
			pv = y_s1[COMPONENT_BITS-1] ? DEN_W'(mx_s1) : twice_s - DEN_W'(mx_s1);
		end else begin
			pu = DEN_W'(xs);
			pv = DEN_W'(ys);
		end
		nu = {pu, {CODE_BITS{1'b0}}} - NUM_W'(pu);
		nv = {pv, {CODE_BITS{1'b0}}} - NUM_W'(pv);
		word_d.zero  = (s_s1 == '0);
		word_d.den   = twice_s;
		word_d.u.rem = nu[NUM_W-1:CODE_BITS];
		word_d.u.low = nu[CODE_BITS-1:0];
		word_d.u.quo = '0;
		word_d.v.rem = nv[NUM_W-1:CODE_BITS];
		word_d.v.low = nv[CODE_BITS-1:0];
		word_d.v.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else if (en) begin
			vld[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w[0] <= word_d;
		end
	end

	for (genvar gi = 0; gi < CODE_BITS; gi++) begin : g_cell
		oct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vld[gi]),
			.in_word   (w[gi]),
			.out_valid (vld[gi+1]),
			.out_word  (w[gi+1])
		);
	end

	assign coord.valid       = vld[CODE_BITS];
	assign coord.zero_vector = w[CODE_BITS].zero;
	assign coord.coord_u     = w[CODE_BITS].zero ? '0 : w[CODE_BITS].u.quo;
	assign coord.coord_v     = w[CODE_BITS].zero ? '0 : w[CODE_BITS].v.quo;

	`OCT_ASSERT(a_ready_when_empty, clk, arst_n, !coord.valid |-> normal.ready)
	`OCT_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, vld[CODE_BITS] && $stable(w[CODE_BITS]))
	`OCT_ASSERT_NEXT(a_entry_moves, clk, arst_n, en && vld_s1, vld[0])

	for (genvar gi = 1; gi <= CODE_BITS; gi++) begin : g_chk
		`OCT_ASSERT(a_rem_lt_den, clk, arst_n, vld[gi] && !w[gi].zero |-> (w[gi].u.rem < w[gi].den) && (w[gi].v.rem < w[gi].den))
	end
endmodule
`default_nettype wire

/* sv/oct_cell.sv */
// One divider cell: a restoring step that yields one quotient bit for both lanes.
// Depends on oct_pkg.
`default_nettype none
module oct_cell
	import oct_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      en,
	input  wire logic      in_valid,
	input  wire oct_word_t in_word,
	output logic           out_valid,
	output oct_word_t      out_word
);
	oct_word_t word_d;

	function automatic oct_lane_t div_step(oct_lane_t ln, logic [DEN_W-1:0] den);
		logic [DEN_W:0] t;
		logic           ge;
		oct_lane_t      r;
		t      = {ln.rem, ln.low[CODE_BITS-1]};
		ge     = (t >= {1'b0, den});
		r.rem  = ge ? DEN_W'(t - {1'b0, den}) : DEN_W'(t);
		r.low  = {ln.low[CODE_BITS-2:0], 1'b0};
		r.quo  = {ln.quo[CODE_BITS-2:0], ge};
		return r;
	endfunction

	always_comb begin
		word_d.zero = in_word.zero;
		word_d.den  = in_word.den;
		word_d.u    = div_step(in_word.u, in_word.den);
		word_d.v    = div_step(in_word.v, in_word.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_word <= word_d;
		end
	end
endmodule
`default_nettype wire
